// ===== src/mpms_pkg.sv =====
package mpms_pkg;

    localparam int NODES         = 1024;
    localparam int ALPHABET      = 256;
    localparam int SYMBOL_OFFSET = 0;
    localparam int MAX_REPORTS   = 64;

    localparam int KIND_W  = 2;
    localparam int SYM_W   = 8;
    localparam int NODE_W  = 10;
    localparam int POS_W   = 32;
    localparam int TOTAL_W = 48;

    localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SYM_AW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int TRANS_AW = $clog2(NODES * ALPHABET);
    localparam int REP_W    = $clog2(MAX_REPORTS + 1);

    localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRANS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INFO    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] word_link;
        logic [NODE_W-1:0] next_word_link;
        logic [NODE_W-1:0] word_index;
        logic [NODE_W-1:0] depth;
        logic [NODE_W-1:0] suffix_count;
    } node_info_t;

    typedef struct packed {
        logic                trans_we;
        logic                trans_re;
        logic                trans_zero;
        logic [TRANS_AW-1:0] trans_addr;
        logic [NODE_W-1:0]   trans_wdata;
        logic                info_we;
        logic                info_re;
        logic                info_zero;
        logic [NODE_AW-1:0]  info_addr;
        node_info_t          info_wdata;
    } tbl_req_t;

    function automatic logic node_in_range(logic [NODE_W-1:0] n);
        return (32'(n) < NODES);
    endfunction

endpackage

// ===== src/mpms_if.sv =====
interface mpms_in_if;
    import mpms_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] next_node;
    logic [NODE_W-1:0] word_link;
    logic [NODE_W-1:0] next_word_link;
    logic [NODE_W-1:0] word_index;
    logic [NODE_W-1:0] depth;
    logic [NODE_W-1:0] suffix_count;

    modport source (
        output valid, kind, symbol, node, next_node, word_link, next_word_link,
               word_index, depth, suffix_count,
        input  ready
    );

    modport sink (
        input  valid, kind, symbol, node, next_node, word_link, next_word_link,
               word_index, depth, suffix_count,
        output ready
    );
endinterface

interface mpms_out_if;
    import mpms_pkg::*;

    logic               valid;
    logic               ready;
    logic               match_valid;
    logic [NODE_W-1:0]  match_word;
    logic [POS_W-1:0]   start_position;
    logic [TOTAL_W-1:0] running_total;
    logic               overflow;
    logic               last;

    modport source (
        output valid, match_valid, match_word, start_position, running_total,
               overflow, last,
        input  ready
    );

    modport sink (
        input  valid, match_valid, match_word, start_position, running_total,
               overflow, last,
        output ready
    );
endinterface

// ===== src/mpms_tables.sv =====
module mpms_tables (
    input  logic                  clk,
    input  mpms_pkg::tbl_req_t    req,
    output logic [mpms_pkg::NODE_W-1:0] trans_q,
    output mpms_pkg::node_info_t  info_q
);
    import mpms_pkg::*;

    logic [NODE_W-1:0] trans_mem [NODES*ALPHABET];
    node_info_t        info_mem  [NODES];

    logic [NODE_W-1:0] trans_rd_reg;
    logic              trans_zero_reg;
    node_info_t        info_rd_reg;
    logic              info_zero_reg;

    always_ff @(posedge clk)
    begin
        if (req.trans_we)
        begin
            trans_mem[req.trans_addr] <= req.trans_wdata;
        end
        if (req.trans_re)
        begin
            trans_rd_reg   <= trans_mem[req.trans_addr];
            trans_zero_reg <= req.trans_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.info_we)
        begin
            info_mem[req.info_addr] <= req.info_wdata;
        end
        if (req.info_re)
        begin
            info_rd_reg   <= info_mem[req.info_addr];
            info_zero_reg <= req.info_zero;
        end
    end

    // out-of-range reads answer as zero
    assign trans_q = trans_zero_reg ? '0 : trans_rd_reg;
    assign info_q  = info_zero_reg ? '0 : info_rd_reg;

endmodule

// ===== src/multi_pattern_match_scanner.sv =====
// a load or restart item is done in the idle state; a text symbol reads the transition table,
// then the node info, and with nothing to report loads one result into the output register,
// else walks the word links, one node info read per match, both waiting while the output
// register stalls; no new item is taken until a text symbol's last result is registered
// reset: current node, position and total clear, report_mode is 1, tables hold no
// defined contents until loaded
module multi_pattern_match_scanner (
    input  logic       clk,
    input  logic       rst_n,
    mpms_in_if.sink    symbols,
    mpms_out_if.source reports,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import mpms_pkg::*;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] ST_TRANS = 2'd1;
    localparam logic [ST_W-1:0] ST_INFO  = 2'd2;
    localparam logic [ST_W-1:0] ST_WALK  = 2'd3;

    logic [ST_W-1:0]    state_reg, state_next;
    logic [NODE_W-1:0]  cur_node_reg, cur_node_next;
    logic [POS_W-1:0]   text_pos_reg, text_pos_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [REP_W-1:0]   count_reg, count_next;
    logic               mode_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_match_reg, out_match_next;
    logic [NODE_W-1:0]  out_word_reg, out_word_next;
    logic [POS_W-1:0]   out_start_reg, out_start_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_last_reg, out_last_next;

    tbl_req_t           req;
    logic [NODE_W-1:0]  trans_q;
    node_info_t         info_q;

    logic               accept;
    logic               out_free;
    logic [SYM_W:0]     sym_diff;
    logic               sym_ok;
    logic [SYM_AW-1:0]  sym_idx;
    logic [TOTAL_W:0]   total_sum;
    logic [REP_W-1:0]   count_inc;
    logic               walk_end;

    mpms_tables u_tables (
        .clk     (clk),
        .req     (req),
        .trans_q (trans_q),
        .info_q  (info_q)
    );

    assign symbols.ready = (state_reg == ST_IDLE);
    assign accept        = symbols.valid && symbols.ready;
    assign out_free      = !out_valid_reg || reports.ready;

    assign sym_diff  = {1'b0, symbols.symbol} - (SYM_W+1)'(SYMBOL_OFFSET);
    assign sym_ok    = !sym_diff[SYM_W] && (32'(sym_diff) < ALPHABET);
    assign sym_idx   = sym_diff[SYM_AW-1:0];
    assign total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(info_q.suffix_count);
    assign count_inc = count_reg + REP_W'(1);
    assign walk_end  = (info_q.next_word_link == '0) || (32'(count_inc) == MAX_REPORTS);

    always_comb
    begin
        state_next    = state_reg;
        cur_node_next = cur_node_reg;
        text_pos_next = text_pos_reg;
        total_next    = total_reg;
        count_next    = count_reg;

        out_valid_next = out_valid_reg && !reports.ready;
        out_match_next = out_match_reg;
        out_word_next  = out_word_reg;
        out_start_next = out_start_reg;
        out_total_next = out_total_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        req             = '0;
        req.trans_addr  = TRANS_AW'(32'(cur_node_reg) * ALPHABET + 32'(sym_idx));
        req.trans_wdata = symbols.next_node;
        req.info_addr   = symbols.node[NODE_AW-1:0];
        req.info_wdata  = '{word_link:      symbols.word_link,
                            next_word_link: symbols.next_word_link,
                            word_index:     symbols.word_index,
                            depth:          symbols.depth,
                            suffix_count:   symbols.suffix_count};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (symbols.kind)
                        KIND_TEXT:
                        begin
                            req.trans_re   = 1'b1;
                            req.trans_zero = !(sym_ok && node_in_range(cur_node_reg));
                            text_pos_next  = text_pos_reg + POS_W'(1);
                            state_next     = ST_TRANS;
                        end
                        KIND_TRANS:
                        begin
                            req.trans_addr = TRANS_AW'(32'(symbols.node) * ALPHABET
                                                       + 32'(sym_idx));
                            req.trans_we   = sym_ok && node_in_range(symbols.node);
                        end
                        KIND_INFO:
                        begin
                            req.info_we = node_in_range(symbols.node);
                        end
                        KIND_RESTART:
                        begin
                            cur_node_next = '0;
                            text_pos_next = '0;
                            total_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TRANS:
            begin
                cur_node_next = trans_q;
                req.info_re   = 1'b1;
                req.info_addr = trans_q[NODE_AW-1:0];
                req.info_zero = !node_in_range(trans_q);
                state_next    = ST_INFO;
            end
            ST_INFO:
            begin
                if (!mode_reg || info_q.word_link == '0)
                begin
                    // nothing to report: one result carrying the total
                    if (out_free)
                    begin
                        total_next     = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                        out_valid_next = 1'b1;
                        out_match_next = 1'b0;
                        out_word_next  = '0;
                        out_start_next = '0;
                        out_total_next = total_next;
                        out_ovf_next   = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    total_next    = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                    count_next    = '0;
                    req.info_re   = 1'b1;
                    req.info_addr = info_q.word_link[NODE_AW-1:0];
                    req.info_zero = !node_in_range(info_q.word_link);
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_match_next = 1'b1;
                    out_word_next  = info_q.word_index;
                    out_start_next = text_pos_reg - POS_W'(info_q.depth);
                    out_total_next = total_reg;
                    out_ovf_next   = walk_end && (info_q.next_word_link != '0);
                    out_last_next  = walk_end;
                    count_next     = count_inc;
                    if (walk_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        req.info_re   = 1'b1;
                        req.info_addr = info_q.next_word_link[NODE_AW-1:0];
                        req.info_zero = !node_in_range(info_q.next_word_link);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_node_reg  <= '0;
            text_pos_reg  <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            mode_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_node_reg  <= cur_node_next;
            text_pos_reg  <= text_pos_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_match_reg <= out_match_next;
        out_word_reg  <= out_word_next;
        out_start_reg <= out_start_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign reports.valid          = out_valid_reg;
    assign reports.match_valid    = out_match_reg;
    assign reports.match_word     = out_word_reg;
    assign reports.start_position = out_start_reg;
    assign reports.running_total  = out_total_reg;
    assign reports.overflow       = out_ovf_reg;
    assign reports.last           = out_last_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mpms_pkg::*;

    localparam int LIVE_N     = 10;
    localparam int SYM_N      = 6;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  symbol;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] next_node;
        node_info_t        info;
    } scan_item_t;

    typedef struct packed {
        logic               match_valid;
        logic [NODE_W-1:0]  match_word;
        logic [POS_W-1:0]   start_position;
        logic [TOTAL_W-1:0] running_total;
        logic               overflow;
        logic               last;
    } match_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    scan_item_t in_item = '0;
    logic       in_valid = 1'b0;
    logic       out_ready = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;

    mpms_in_if  symbols_if ();
    mpms_out_if reports_if ();

    assign symbols_if.valid          = in_valid;
    assign symbols_if.kind           = in_item.kind;
    assign symbols_if.symbol         = in_item.symbol;
    assign symbols_if.node           = in_item.node;
    assign symbols_if.next_node      = in_item.next_node;
    assign symbols_if.word_link      = in_item.info.word_link;
    assign symbols_if.next_word_link = in_item.info.next_word_link;
    assign symbols_if.word_index     = in_item.info.word_index;
    assign symbols_if.depth          = in_item.info.depth;
    assign symbols_if.suffix_count   = in_item.info.suffix_count;
    assign reports_if.ready          = out_ready;

    multi_pattern_match_scanner DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbols   (symbols_if.sink),
        .reports   (reports_if.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // scanner state as the block should hold it
    logic [NODE_W-1:0]  goto_tbl [NODES*ALPHABET];
    node_info_t         info_tbl [NODES];
    logic [NODE_W-1:0]  scan_node = '0;
    logic [POS_W-1:0]   scan_pos = '0;
    logic [TOTAL_W-1:0] scan_total = '0;
    logic               scan_mode = 1'b1;

    scan_item_t    pending_items [$];
    match_report_t expected_reports [$];

    scan_item_t drv_cur = '0;
    bit         drv_busy = 1'b0;
    int         drv_gap = 0;
    int         mon_stall = 0;
    bit         burst = 1'b0;
    int         err_count = 0;
    int         cycle_count = 0;

    logic [NODE_W-1:0] live_nodes [LIVE_N];
    logic [SYM_W-1:0]  text_syms [SYM_N];

    task automatic advance_scanner(input scan_item_t it);
        int                s;
        int                n;
        logic [TRANS_AW-1:0] ga;
        logic [NODE_W-1:0] nxt;
        logic [NODE_W-1:0] par;
        logic [POS_W-1:0]  pos;
        logic [TOTAL_W:0]  sum;
        node_info_t        hit;
        match_report_t     r;
        match_report_t     batch [$];
        s = int'(it.symbol) - SYMBOL_OFFSET;
        case (it.kind)
            KIND_TRANS:
            begin
                if (s >= 0 && s < ALPHABET && int'(it.node) < NODES)
                begin
                    ga = TRANS_AW'(int'(it.node) * ALPHABET + s);
                    goto_tbl[ga] = it.next_node;
                end
            end
            KIND_INFO:
            begin
                if (int'(it.node) < NODES)
                    info_tbl[it.node] = it.info;
            end
            KIND_RESTART:
            begin
                scan_node  = '0;
                scan_pos   = '0;
                scan_total = '0;
            end
            default:
            begin
                nxt = '0;
                if (s >= 0 && s < ALPHABET && int'(scan_node) < NODES)
                begin
                    ga  = TRANS_AW'(int'(scan_node) * ALPHABET + s);
                    nxt = goto_tbl[ga];
                end
                scan_node = nxt;
                pos = scan_pos;
                scan_pos = pos + 32'd1;
                if (int'(scan_node) < NODES)
                begin
                    sum = {1'b0, scan_total} + (TOTAL_W+1)'(info_tbl[scan_node].suffix_count);
                    scan_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                end
                r = '0;
                r.running_total = scan_total;
                n = 0;
                par = '0;
                if (scan_mode && int'(scan_node) < NODES)
                    par = info_tbl[scan_node].word_link;
                // walk the word-link chain, cut after the report limit
                while (par != '0 && n < MAX_REPORTS)
                begin
                    hit = '0;
                    if (int'(par) < NODES)
                        hit = info_tbl[par];
                    r.match_valid    = 1'b1;
                    r.match_word     = hit.word_index;
                    r.start_position = pos + 32'd1 - POS_W'(hit.depth);
                    batch = {batch, r};
                    n++;
                    par = hit.next_word_link;
                end
                if (n == 0)
                begin
                    r.last = 1'b1;
                    expected_reports = {expected_reports, r};
                end
                else
                begin
                    batch[n-1].last     = 1'b1;
                    batch[n-1].overflow = (par != '0);
                    expected_reports = {expected_reports, batch};
                end
            end
        endcase
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drv_busy && symbols_if.ready)
            begin
                advance_scanner(drv_cur);
                drv_busy = 1'b0;
            end
            if (!drv_busy)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pending_items.size() != 0)
                begin
                    drv_cur  = pending_items.pop_front();
                    drv_busy = 1'b1;
                    drv_gap  = burst ? 0 : $urandom_range(0, 6);
                end
            end
            in_valid <= drv_busy;
            in_item  <= drv_cur;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        match_report_t want;
        if (rst_n)
        begin
            if (out_ready && reports_if.valid)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report item with nothing expected");
                    err_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (reports_if.match_valid !== want.match_valid)
                    begin
                        $error("match_valid expected %0d got %0d",
                               want.match_valid, reports_if.match_valid);
                        err_count++;
                    end
                    if (reports_if.match_word !== want.match_word)
                    begin
                        $error("match_word expected %0d got %0d",
                               want.match_word, reports_if.match_word);
                        err_count++;
                    end
                    if (reports_if.start_position !== want.start_position)
                    begin
                        $error("start_position expected %0d got %0d",
                               want.start_position, reports_if.start_position);
                        err_count++;
                    end
                    if (reports_if.running_total !== want.running_total)
                    begin
                        $error("running_total expected %0d got %0d",
                               want.running_total, reports_if.running_total);
                        err_count++;
                    end
                    if (reports_if.overflow !== want.overflow)
                    begin
                        $error("overflow expected %0d got %0d",
                               want.overflow, reports_if.overflow);
                        err_count++;
                    end
                    if (reports_if.last !== want.last)
                    begin
                        $error("last expected %0d got %0d", want.last, reports_if.last);
                        err_count++;
                    end
                end
                mon_stall = burst ? 0 : $urandom_range(0, 6);
            end
            if (mon_stall > 0)
            begin
                mon_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // irrelevant fields carry random noise
    function automatic scan_item_t noise_item(input logic [KIND_W-1:0] k);
        scan_item_t  it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(scan_item_t)-1:0];
        it.kind = k;
        return it;
    endfunction

    function automatic logic [NODE_W-1:0] pick_live();
        return live_nodes[$urandom_range(0, LIVE_N-1)];
    endfunction

    function automatic logic [SYM_W-1:0] pick_sym();
        return text_syms[$urandom_range(0, SYM_N-1)];
    endfunction

    function automatic scan_item_t text_item(input logic [SYM_W-1:0] sym);
        scan_item_t it;
        it = noise_item(KIND_TEXT);
        it.symbol = sym;
        return it;
    endfunction

    function automatic scan_item_t trans_item(input logic [NODE_W-1:0] nd,
                                              input logic [SYM_W-1:0] sym,
                                              input logic [NODE_W-1:0] tgt);
        scan_item_t it;
        it = noise_item(KIND_TRANS);
        it.node      = nd;
        it.symbol    = sym;
        it.next_node = tgt;
        return it;
    endfunction

    function automatic scan_item_t info_item(input logic [NODE_W-1:0] nd,
                                             input logic [NODE_W-1:0] wl,
                                             input logic [NODE_W-1:0] nwl,
                                             input logic [NODE_W-1:0] wi,
                                             input logic [NODE_W-1:0] dep,
                                             input logic [NODE_W-1:0] cnt);
        scan_item_t it;
        it = noise_item(KIND_INFO);
        it.node                = nd;
        it.info.word_link      = wl;
        it.info.next_word_link = nwl;
        it.info.word_index     = wi;
        it.info.depth          = dep;
        it.info.suffix_count   = cnt;
        return it;
    endfunction

    // links stay inside the loaded node set so no unwritten entry is ever read
    function automatic scan_item_t random_info(input logic [NODE_W-1:0] nd);
        logic [NODE_W-1:0] wl;
        logic [NODE_W-1:0] nwl;
        wl  = ($urandom_range(0, 2) == 0) ? '0 : pick_live();
        nwl = ($urandom_range(0, 1) == 0) ? '0 : pick_live();
        return info_item(nd, wl, nwl, NODE_W'($urandom), NODE_W'($urandom),
                         NODE_W'($urandom));
    endfunction

    function automatic scan_item_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return text_item(pick_sym());
        else if (r < 80)
            return noise_item(KIND_RESTART);
        else if (r < 88)
            return random_info(pick_live());
        else if (r < 95)
            return trans_item(pick_live(), pick_sym(), pick_live());
        else if (r < 98)
            return trans_item(NODE_W'($urandom), SYM_W'($urandom), pick_live());
        else
            return random_info(NODE_W'($urandom));
    endfunction

    task automatic add_item(input scan_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            add_item(random_item());
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || drv_busy || expected_reports.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_report_mode(input logic m);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        scan_mode = m;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        live_nodes[0] = 10'd0;
        live_nodes[1] = 10'd1023;
        live_nodes[2] = 10'd512;
        live_nodes[3] = 10'd341;
        live_nodes[4] = 10'd682;
        live_nodes[5] = NODE_W'($urandom_range(1, 300));
        live_nodes[6] = NODE_W'($urandom_range(350, 500));
        live_nodes[7] = NODE_W'($urandom_range(520, 670));
        live_nodes[8] = NODE_W'($urandom_range(690, 850));
        live_nodes[9] = NODE_W'($urandom_range(860, 1000));
        text_syms[0] = 8'h00;
        text_syms[1] = 8'hFF;
        text_syms[2] = 8'h55;
        text_syms[3] = 8'hAA;
        text_syms[4] = SYM_W'($urandom_range(1, 84));
        text_syms[5] = SYM_W'($urandom_range(86, 169));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_report_mode(1'b1);

        // load every node that the text can reach, on every text symbol
        foreach (live_nodes[i])
        begin
            add_item(random_info(live_nodes[i]));
            foreach (text_syms[j])
                add_item(trans_item(live_nodes[i], text_syms[j], pick_live()));
        end

        // directed: extremes, self-looping word link, wrapped start, short chain
        add_item(noise_item(KIND_RESTART));
        add_item(info_item(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023));
        add_item(info_item(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
        add_item(trans_item(10'd0, 8'hFF, 10'd1023));
        add_item(trans_item(10'd1023, 8'hFF, 10'd1023));
        add_item(trans_item(10'd1023, 8'h00, 10'd0));
        add_item(trans_item(10'd0, 8'h00, 10'd0));
        add_item(text_item(8'h00));
        add_item(text_item(8'hFF));
        add_item(text_item(8'hFF));
        add_item(text_item(8'h00));
        add_item(info_item(10'd512, 10'd341, 10'd0, 10'd77, 10'd1, 10'd3));
        add_item(info_item(10'd341, 10'd0, 10'd682, 10'd300, 10'd2, 10'd1));
        add_item(info_item(10'd682, 10'd0, 10'd0, 10'd640, 10'd0, 10'd2));
        add_item(trans_item(10'd0, 8'h55, 10'd512));
        add_item(text_item(8'h55));
        add_item(noise_item(KIND_RESTART));
        add_item(text_item(8'hFF));
        add_item(text_item(8'h00));
        add_item(text_item(8'h55));
        wait_drained();

        set_report_mode(1'b0);
        queue_random(60);
        wait_drained();

        set_report_mode(1'b1);
        queue_random(80);
        // no new items are queued until every report has come back
        wait_drained();
        burst = 1'b1;
        queue_random(40);
        wait_drained();
        burst = 1'b0;
        queue_random(40);
        wait_drained();

        set_report_mode(1'b0);
        queue_random(40);
        wait_drained();

        set_report_mode(1'b1);
        queue_random(90);
        wait_drained();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== multi_pattern_match_scanner.f =====
src/mpms_pkg.sv
src/mpms_if.sv
src/mpms_tables.sv
src/multi_pattern_match_scanner.sv
sim/tb_top.sv
